[rtl/hof_pkg.sv]
package hof_pkg;

	localparam int MaxWindow = 11;
	localparam int MinHeld = 3;
	localparam int DefaultWindow = 7;
	localparam int SampleW = 32;

	typedef enum logic [1:0] {
		REG_ENABLE    = 2'd0,
		REG_WINDOW    = 2'd1,
		REG_THRESHOLD = 2'd2,
		REG_SCALE     = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STORE,
		ST_LOAD1,
		ST_SORT1,
		ST_MED,
		ST_LOAD2,
		ST_SORT2,
		ST_MAD,
		ST_MUL1,
		ST_MUL2,
		ST_DECIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic store;
		logic load_samples;
		logic load_devs;
		logic sort_step;
		logic take_med;
		logic take_mad;
		logic mul1;
		logic mul2;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic enabled;
		logic few;
		logic sort_done;
	} status_t;

endpackage

[rtl/hof_stream_if.sv]
interface hof_stream_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/hof_ctrl.sv]
module hof_ctrl
	import hof_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    out_fire,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    result_valid
);

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_next = ST_STORE;
			ST_STORE:  state_next = (!status.enabled) ? ST_DONE : ST_LOAD1;
			ST_LOAD1:  state_next = status.few ? ST_DONE : ST_SORT1;
			ST_SORT1:  if (status.sort_done) state_next = ST_MED;
			ST_MED:    state_next = ST_LOAD2;
			ST_LOAD2:  state_next = ST_SORT2;
			ST_SORT2:  if (status.sort_done) state_next = ST_MAD;
			ST_MAD:    state_next = ST_MUL1;
			ST_MUL1:   state_next = ST_MUL2;
			ST_MUL2:   state_next = ST_DECIDE;
			ST_DECIDE: state_next = ST_DONE;
			ST_DONE:   if (out_fire) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_STORE:  cmd.store = 1'b1;
			ST_LOAD1:  cmd.load_samples = 1'b1;
			ST_SORT1:  cmd.sort_step = 1'b1;
			ST_MED:    cmd.take_med = 1'b1;
			ST_LOAD2:  cmd.load_devs = 1'b1;
			ST_SORT2:  cmd.sort_step = 1'b1;
			ST_MAD:    cmd.take_mad = 1'b1;
			ST_MUL1:   cmd.mul1 = 1'b1;
			ST_MUL2:   cmd.mul2 = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			default:   ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_DONE);

endmodule

[rtl/hof_datapath.sv]
module hof_datapath
	import hof_pkg::*;
#(
	parameter int MAX_WINDOW = MaxWindow
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic              in_fire,
	input  logic [31:0]       sample_in,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output status_t           status,
	output logic [31:0]       sample_out,
	output logic              replaced
);

	localparam int IW = $clog2(MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam logic [3:0] DefW = (DefaultWindow <= MAX_WINDOW) ?
		4'(DefaultWindow) : 4'(MAX_WINDOW);

	logic        enable_q;
	logic [3:0]  wlen_q;
	logic [15:0] thr_q, scale_q;
	logic [IW-1:0] wp_q;
	logic [3:0]  fill_q;
	logic [31:0] x_q;
	logic [31:0] win_q [MAX_WINDOW];
	logic [31:0] srt_q [MAX_WINDOW];
	logic        sgn_q;
	logic [CW-1:0] pass_q;
	logic [31:0] med_q, mad_q;
	logic [31:0] prod_q;
	logic [63:0] lim_q;
	logic [31:0] out_q;
	logic        rep_q;
	logic [CW-1:0] n;
	logic [3:0]  wlen_new;
	logic [IW:0] wp_inc;
	logic [32:0] mid_sum;
	logic [31:0] mid_a, mid_b, mid_val, x_dev;

	assign n = (int'(fill_q) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(fill_q);
	assign wlen_new = (int'(cfg_data[3:0]) < MinHeld || int'(cfg_data[3:0]) > MAX_WINDOW) ?
		DefW : cfg_data[3:0];
	assign wp_inc = {1'b0, wp_q} + 1'b1;

	function automatic logic gt(input logic [31:0] a, input logic [31:0] b, input logic s);
		gt = s ? ($signed(a) > $signed(b)) : (a > b);
	endfunction

	function automatic logic [31:0] adiff(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		adiff = d[32] ? 32'(-d) : d[31:0];
	endfunction

	assign mid_a = srt_q[IW'((n - 1'b1) >> 1)];
	assign mid_b = srt_q[IW'(n >> 1)];
	assign mid_sum = sgn_q ? ({mid_a[31], mid_a} + {mid_b[31], mid_b})
		: ({1'b0, mid_a} + {1'b0, mid_b});
	assign mid_val = n[0] ? mid_b : mid_sum[32:1];
	assign x_dev = adiff(x_q, med_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			wlen_q   <= DefW;
			thr_q    <= 16'd768;
			scale_q  <= 16'd24291;
			wp_q     <= '0;
			fill_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE:    enable_q <= cfg_data[0];
				REG_WINDOW:    wlen_q <= wlen_new;
				REG_THRESHOLD: thr_q <= cfg_data;
				REG_SCALE:     scale_q <= cfg_data;
				default: ;
			endcase
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.store && enable_q) begin
			wp_q <= (wp_inc >= (IW+1)'(wlen_q)) ? '0 : wp_q + 1'b1;
			if (fill_q < wlen_q) fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) x_q <= sample_in;
		if (cmd.store && enable_q) win_q[wp_q] <= x_q;
		if (cmd.load_samples || cmd.load_devs) pass_q <= '0;
		else if (cmd.sort_step) pass_q <= pass_q + 1'b1;
		if (cmd.load_samples) begin
			sgn_q <= 1'b1;
			for (int i = 0; i < MAX_WINDOW; i++) srt_q[i] <= win_q[i];
		end else if (cmd.load_devs) begin
			sgn_q <= 1'b0;
			for (int i = 0; i < MAX_WINDOW; i++) srt_q[i] <= adiff(win_q[i], med_q);
		end else if (cmd.sort_step) begin
			for (int i = 0; i + 1 < MAX_WINDOW; i++) begin
				if ((i % 2) == int'(pass_q[0]) && (i + 1) < int'(n)
					&& gt(srt_q[i], srt_q[i+1], sgn_q)) begin
					srt_q[i]   <= srt_q[i+1];
					srt_q[i+1] <= srt_q[i];
				end
			end
		end
		if (cmd.take_med) med_q <= mid_val;
		if (cmd.take_mad) mad_q <= mid_val;
		if (cmd.mul1) prod_q <= {16'd0, thr_q} * {16'd0, scale_q};
		if (cmd.mul2) lim_q <= {32'd0, prod_q} * {32'd0, mad_q};
		if (cmd.store) begin
			out_q <= x_q;
			rep_q <= 1'b0;
		end
		if (cmd.decide && ({10'd0, x_dev, 22'd0} > lim_q)) begin
			out_q <= med_q;
			rep_q <= 1'b1;
		end
	end

	assign status.enabled = enable_q;
	assign status.few = (n < CW'(MinHeld));
	assign status.sort_done = (pass_q >= n);
	assign sample_out = out_q;
	assign replaced = rep_q;

endmodule

[rtl/hampel_outlier_filter_sliding.sv]
// After the input transfer the controller runs ST_STORE then ST_DONE when disabled;
// ST_STORE, ST_LOAD1, ST_DONE with fewer than 3 samples held; when filtering, ST_STORE,
// ST_LOAD1, ST_SORT1, ST_MED, ST_LOAD2, ST_SORT2, ST_MAD, ST_MUL1, ST_MUL2, ST_DECIDE.
// One sample at a time; the next is taken the cycle after the result transfers.
// Sorts run one odd/even exchange pass per cycle over the sort registers (held samples, then deviations).
// Reset (arst_n low): registers to defaults, window pointer and fill count to zero.
module hampel_outlier_filter_sliding
	import hof_pkg::*;
#(
	parameter int MAX_WINDOW = MaxWindow
) (
	input  logic clk,
	input  logic arst_n,
	hof_stream_if.sink   in_ch,
	hof_stream_if.source out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t    cmd;
	status_t status;
	logic    busy, rv, in_fire, out_fire, rep;
	logic [31:0] smp;

	assign in_ch.ready = !busy;
	assign in_fire = in_ch.valid && !busy;
	assign out_fire = rv && out_ch.ready;

	hof_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_fire, .status, .cmd, .busy, .result_valid(rv)
	);

	hof_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
		.clk, .arst_n, .cmd, .in_fire, .sample_in(in_ch.data[31:0]),
		.cfg_we, .cfg_index, .cfg_data, .status, .sample_out(smp), .replaced(rep)
	);

	assign out_ch.valid = rv;
	assign out_ch.data = {rep, smp};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_fire) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rv && !out_ch.ready) |=> rv) else $error("result dropped");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |=> !busy) else $error("not idle after transfer");

endmodule

[tb/hampel_outlier_filter_sliding_test.sv]
`timescale 1ns / 1ps

module hampel_outlier_filter_sliding_test;
	import hof_pkg::*;

	localparam int DrainCycles = 2 * MaxWindow + 20;
	localparam int StallLimit = 3000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [15:0] cfg_data;

	hof_stream_if #(.W(32)) in_ch();
	hof_stream_if #(.W(33)) out_ch();

	hampel_outlier_filter_sliding dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// filter state as seen from outside
	logic enable_q;
	logic [3:0] win_len_q;
	logic [15:0] threshold_q;
	logic [15:0] scale_q;
	logic signed [31:0] window_q[MaxWindow];
	int wr_ptr;
	int held;

	logic [32:0] expected_out[$];
	int errors;
	int quiet_cycles;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [32:0] filter_sample(logic signed [31:0] x);
		logic signed [31:0] srt[MaxWindow];
		logic [31:0] dv[MaxWindow];
		logic signed [31:0] key;
		logic [31:0] ukey;
		logic [31:0] mad;
		longint med;
		longint diff;
		logic [63:0] lim;
		logic [63:0] dev;
		int n;
		int j;
		if (!enable_q)
			return {1'b0, x};
		window_q[wr_ptr] = x;
		wr_ptr++;
		if (wr_ptr >= win_len_q)
			wr_ptr = 0;
		if (held < win_len_q)
			held++;
		n = held;
		if (n < MinHeld)
			return {1'b0, x};
		for (int i = 0; i < n; i++)
			srt[i] = window_q[i];
		for (int i = 1; i < n; i++) begin
			key = srt[i];
			j = i;
			while (j > 0 && srt[j - 1] > key) begin
				srt[j] = srt[j - 1];
				j--;
			end
			srt[j] = key;
		end
		if (n % 2)
			med = longint'(srt[n / 2]);
		else
			med = (longint'(srt[n / 2 - 1]) + longint'(srt[n / 2])) >>> 1;
		for (int i = 0; i < n; i++) begin
			diff = longint'(window_q[i]) - med;
			dv[i] = 32'((diff < 0) ? -diff : diff);
		end
		for (int i = 1; i < n; i++) begin
			ukey = dv[i];
			j = i;
			while (j > 0 && dv[j - 1] > ukey) begin
				dv[j] = dv[j - 1];
				j--;
			end
			dv[j] = ukey;
		end
		if (n % 2)
			mad = dv[n / 2];
		else
			mad = 32'(({32'd0, dv[n / 2 - 1]} + {32'd0, dv[n / 2]}) >> 1);
		diff = longint'(x) - med;
		dev = (diff < 0) ? -diff : diff;
		lim = 64'(threshold_q) * 64'(scale_q) * 64'(mad);
		if ((dev << 22) > lim)
			return {1'b1, med[31:0]};
		return {1'b0, x};
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		quiet_cycles = 0;
		case (idx)
			REG_ENABLE: enable_q = value[0];
			REG_WINDOW: win_len_q = (value[3:0] < MinHeld || value[3:0] > MaxWindow) ?
				4'(DefaultWindow) : value[3:0];
			REG_THRESHOLD: threshold_q = value;
			REG_SCALE: scale_q = value;
			default: ;
		endcase
		wr_ptr = 0;
		held = 0;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic program_filter(logic en, logic [15:0] wl, logic [15:0] thr, logic [15:0] scl);
		drain();
		write_reg(REG_WINDOW, wl);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_SCALE, scl);
		write_reg(REG_ENABLE, {15'd0, en});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic [31:0] x);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= x;
		do
			@(posedge clk);
		while (!in_ch.ready);
		expected_out.push_back(filter_sample(x));
	endtask

	function automatic logic [31:0] random_sample(logic [31:0] base);
		case ($urandom_range(9))
			0: return $urandom;
			1: return base + $urandom_range(32'h0100_0000) - 32'h0080_0000;
			default: return base + $urandom_range(32'h0000_4000) - 32'h0000_2000;
		endcase
	endfunction

	task automatic test_passthrough_after_reset();
		send_sample(32'h8000_0000);
		send_sample(32'h7fff_ffff);
		send_sample(32'h0000_0000);
		send_sample(32'hffff_ffff);
	endtask

	task automatic test_directed_cases();
		program_filter(1'b1, 16'd3, 16'd768, 16'd24291);
		send_sample(32'h0001_0000);
		send_sample(32'h0001_0000);
		send_sample(32'h0001_0000);
		send_sample(32'h7fff_ffff);
		send_sample(32'h8000_0000);
		send_sample(32'h8000_0000);
		program_filter(1'b1, 16'd4, 16'hffff, 16'hffff);
		send_sample(32'h7fff_ffff);
		send_sample(32'h8000_0000);
		send_sample(32'h7fff_ffff);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_0003);
		program_filter(1'b1, 16'd0, 16'd0, 16'd24291);
		for (int i = 0; i < 8; i++)
			send_sample(32'h0002_0000 + i * 32'h0000_8001);
		program_filter(1'b1, 16'd15, 16'd768, 16'd0);
		for (int i = 0; i < 5; i++)
			send_sample(32'hfffe_0000 - i);
		program_filter(1'b1, 16'd11, 16'd256, 16'd16384);
		for (int i = 0; i < 12; i++)
			send_sample((i == 9) ? 32'h4000_0000 : 32'h0000_1000 + i);
		program_filter(1'b1, 16'd1, 16'd768, 16'd24291);
		for (int i = 0; i < 4; i++)
			send_sample($urandom);
	endtask

	task automatic test_random_traffic(int items);
		logic [31:0] base;
		logic [15:0] wl;
		logic [15:0] thr;
		base = $urandom;
		for (int i = 0; i < items; i++) begin
			if (i % 80 == 0) begin
				wl = ($urandom_range(4) == 0) ? 16'($urandom_range(15))
					: 16'($urandom_range(MaxWindow, MinHeld));
				thr = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 16'hffff : 16'h0000)
					: 16'($urandom_range(1200, 128));
				program_filter($urandom_range(9) != 0, wl, thr, ($urandom_range(5) == 0) ?
					16'($urandom) : 16'($urandom_range(30000, 12000)));
				base = $urandom;
			end
			send_sample(random_sample(base));
		end
	endtask

	task automatic test_output_backpressure();
		program_filter(1'b1, 16'd11, 16'd768, 16'd24291);
		tx_idle_pct = 0;
		hold_left = 300;
		for (int i = 0; i < 40; i++)
			send_sample(random_sample(32'h0010_0000));
	endtask

	task automatic test_sender_pause();
		for (int i = 0; i < 10; i++)
			send_sample(random_sample(32'hfff0_0000));
		in_ch.valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 10; i++)
			send_sample(random_sample(32'hfff0_0000));
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_ch.data);
				errors++;
			end else begin
				if (out_ch.data[31:0] !== expected_out[0][31:0])
					$display("%0t: sample_out expected %h actual %h", $time,
						expected_out[0][31:0], out_ch.data[31:0]);
				if (out_ch.data[32] !== expected_out[0][32])
					$display("%0t: replaced expected %b actual %b", $time,
						expected_out[0][32], out_ch.data[32]);
				if (out_ch.data !== expected_out[0])
					errors++;
				void'(expected_out.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		hold_left = 0;
		enable_q = 1'b0;
		win_len_q = 4'(DefaultWindow);
		threshold_q = 16'd768;
		scale_q = 16'd24291;
		wr_ptr = 0;
		held = 0;
		foreach (window_q[i])
			window_q[i] = '0;
		tx_idle_pct = 34;
		rx_idle_pct = 72;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough_after_reset();
		test_directed_cases();
		test_random_traffic(420);
		tx_idle_pct = 72;
		rx_idle_pct = 34;
		test_random_traffic(420);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(420);
		test_output_backpressure();
		test_sender_pause();
		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
